[rtl/core/rlos_pkg.sv]
// rlos_pkg: shared types, codes and helpers of the rumble and led output sequencer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rlos_pkg;

   // width of the millisecond countdown
   localparam int TIME_BITS = 16;

   // report queue between front and back (depth must stay a power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // motor duration byte while a rumble plays
   localparam logic [7:0] MOTOR_HOLD_PLAY = 8'hff;

   // input item codes
   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_REPORT = 2'd1,
      ACT_LEDS   = 2'd2,
      ACT_RUMBLE = 2'd3
   } action_type;

   // rumble sequencing state
   typedef enum logic [2:0] {
      RUMBLE_IDLE  = 3'b001,
      RUMBLE_DELAY = 3'b010,
      RUMBLE_RUN   = 3'b100
   } rumble_phase_type;

   // player led state
   typedef enum logic [2:0] {
      LED_INIT = 3'b001,
      LED_NEED = 3'b010,
      LED_DONE = 3'b100
   } led_state_type;

   // one report to be sent, before copying
   typedef struct packed {
      logic       weak_on;
      logic [7:0] strong_force;
      logic [7:0] hold;
      logic [4:0] led_byte;
   } report_type;

   // load a millisecond count, saturated to the countdown width
   function automatic logic [TIME_BITS-1:0] time_load(input logic [15:0] value);
      logic [32:0] ext;
      logic [32:0] max;
      ext = 33'(value);
      max = 33'((64'd1 << TIME_BITS) - 64'd1);
      return TIME_BITS'((ext > max) ? max : ext);
   endfunction

endpackage

[rtl/core/rlos_front.sv]
// rlos_front: accepts items, runs the rumble and led state, and queues reports
// depends on rlos_pkg
`timescale 1ns / 1ps

module rlos_front import rlos_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [3:0] req_led_bits,
   input  logic [15:0] req_start_delay,
   input  logic [15:0] req_run_time,
   input  logic [7:0] req_weak_level,
   input  logic [7:0] req_strong_level,
   input  logic       q_full,
   output logic       q_push,
   output report_type q_data
);

   rumble_phase_type      rumble_ff, rumble_in;
   led_state_type         led_ff, led_in;
   logic [3:0]            led_store_ff, led_store_in;
   logic [TIME_BITS-1:0]  countdown_ff, countdown_in;
   logic [15:0]           held_run_ff, held_run_in;
   logic                  held_weak_ff, held_weak_in;
   logic [7:0]            held_strong_ff, held_strong_in;
   logic                  accept;
   logic                  rep_valid;
   report_type            rep;
   logic                  req_weak_on;

   // an item is taken whenever the queue has room
   assign req_ready   = !q_full;
   assign accept      = req_valid && req_ready;
   assign req_weak_on = (req_weak_level != 8'd0);

   // classify the item and work out the next state and any report
   always_comb begin
      rumble_in      = rumble_ff;
      led_in         = led_ff;
      led_store_in   = led_store_ff;
      countdown_in   = countdown_ff;
      held_run_in    = held_run_ff;
      held_weak_in   = held_weak_ff;
      held_strong_in = held_strong_ff;
      rep_valid      = 1'b0;
      rep            = '0;
      unique case (action_type'(req_action))
         ACT_TICK: begin
            if (rumble_ff == RUMBLE_DELAY || rumble_ff == RUMBLE_RUN) begin
               if (countdown_ff > TIME_BITS'(1)) begin
                  countdown_in = countdown_ff - TIME_BITS'(1);
               end else if (rumble_ff == RUMBLE_RUN) begin
                  // run time elapsed: stop report
                  rumble_in    = RUMBLE_IDLE;
                  countdown_in = '0;
                  rep_valid    = 1'b1;
               end else if (held_run_ff == 16'd0) begin
                  // delay over with nothing to play
                  rumble_in    = RUMBLE_IDLE;
                  countdown_in = '0;
               end else begin
                  // delay over: start the held rumble
                  rumble_in        = RUMBLE_RUN;
                  countdown_in     = time_load(held_run_ff);
                  rep_valid        = 1'b1;
                  rep.weak_on      = held_weak_ff;
                  rep.strong_force = held_strong_ff;
                  rep.hold         = MOTOR_HOLD_PLAY;
               end
            end
         end
         ACT_REPORT: begin
            if (led_ff == LED_NEED) begin
               led_in    = LED_DONE;
               rep_valid = 1'b1;
            end
         end
         ACT_LEDS: begin
            led_store_in = req_led_bits;
            if (led_ff == LED_INIT || led_ff == LED_NEED) begin
               led_in = LED_NEED;
            end else begin
               led_in    = LED_DONE;
               rep_valid = 1'b1;
            end
         end
         ACT_RUMBLE: begin
            if (req_start_delay != 16'd0) begin
               rumble_in      = RUMBLE_DELAY;
               held_run_in    = req_run_time;
               held_weak_in   = req_weak_on;
               held_strong_in = req_strong_level;
               countdown_in   = time_load(req_start_delay);
            end else if (req_run_time == 16'd0) begin
               // zero run time: stop a running rumble, clear a pending one
               rep_valid    = (rumble_ff == RUMBLE_RUN);
               rumble_in    = RUMBLE_IDLE;
               countdown_in = '0;
            end else begin
               rumble_in        = RUMBLE_RUN;
               countdown_in     = time_load(req_run_time);
               rep_valid        = 1'b1;
               rep.weak_on      = req_weak_on;
               rep.strong_force = req_strong_level;
               rep.hold         = MOTOR_HOLD_PLAY;
            end
         end
         default: begin
         end
      endcase
      rep.led_byte = {led_store_in, 1'b0};
   end

   assign q_push = accept && rep_valid;
   assign q_data = rep;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rumble_ff      <= RUMBLE_IDLE;
         led_ff         <= LED_INIT;
         led_store_ff   <= '0;
         countdown_ff   <= '0;
         held_run_ff    <= '0;
         held_weak_ff   <= 1'b0;
         held_strong_ff <= '0;
      end else if (accept) begin
         rumble_ff      <= rumble_in;
         led_ff         <= led_in;
         led_store_ff   <= led_store_in;
         countdown_ff   <= countdown_in;
         held_run_ff    <= held_run_in;
         held_weak_ff   <= held_weak_in;
         held_strong_ff <= held_strong_in;
      end
   end

endmodule

[rtl/core/rlos_queue.sv]
// rlos_queue: short register queue of reports between front and back
// depends on rlos_pkg
`timescale 1ns / 1ps

module rlos_queue import rlos_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  report_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output report_type head_data
);

   report_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0]    count_ff, count_in;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // occupancy never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // the front never writes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   // the back never takes from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

[rtl/core/rlos_back.sv]
// rlos_back: sends each queued report once, or twice in clone mode
// depends on rlos_pkg
`timescale 1ns / 1ps

module rlos_back import rlos_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       clone_mode,
   input  logic       head_valid,
   input  report_type head_data,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_weak_motor_on,
   output logic [7:0] rsp_strong_force,
   output logic [7:0] rsp_motor_hold,
   output logic [4:0] rsp_led_byte,
   output logic       rsp_interrupt_channel,
   output logic       rsp_last_copy
);

   logic       valid_ff;
   report_type rep_ff;
   logic       intr_ff;
   logic       last_ff;
   logic       taken;
   logic       out_free;

   assign taken    = valid_ff && rsp_ready;
   assign out_free = !valid_ff || (taken && last_ff);
   assign pop      = out_free && head_valid;

   // output register: load a new report or move on to the interrupt copy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         intr_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else if (taken && !last_ff) begin
         intr_ff <= 1'b1;
         last_ff <= 1'b1;
      end else if (out_free) begin
         valid_ff <= head_valid;
         intr_ff  <= 1'b0;
         last_ff  <= !clone_mode;
      end
   end

   // report payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rep_ff <= head_data;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_weak_motor_on     = rep_ff.weak_on;
   assign rsp_strong_force      = rep_ff.strong_force;
   assign rsp_motor_hold        = rep_ff.hold;
   assign rsp_led_byte          = rep_ff.led_byte;
   assign rsp_interrupt_channel = intr_ff;
   assign rsp_last_copy         = last_ff;

   // the interrupt copy is always the final one
   a_intr_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && intr_ff) |-> last_ff)
      else $error("interrupt copy not marked last");

   // a first copy that is not last goes out on the control channel
   a_first_ctrl: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> !intr_ff)
      else $error("non-final copy on interrupt channel");

   // taking a non-final copy brings up the interrupt copy of the same report
   a_second_copy: assert property (@(posedge clock) disable iff (reset)
      (taken && !last_ff) |=> (valid_ff && intr_ff && $stable(rep_ff)))
      else $error("second copy missing");

endmodule

[rtl/core/rumble_led_output_sequencer_unit.sv]
// rumble_led_output_sequencer_unit: top level of the rumble and led sequencer
// depends on rlos_pkg, rlos_front, rlos_queue, rlos_back
`timescale 1ns / 1ps

//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    action, led bits, delay, run time, levels
//  rsp      out        rsp_valid/rsp_ready    motor fields, led byte, channel, last copy
//  csr      in         csr_valid/csr_ready    clone_mode
//
//  the front takes one item per cycle while the two-entry report queue has room
//  an item with no report leaves the output alone; a report occupies the output for
//  one copy, or two copies in clone mode, so the output register sets the sustained rate
//  reset is synchronous and clears all sequencing state and clone_mode
//  a stalled rsp side fills the queue, then req_ready drops; csr is always ready

module rumble_led_output_sequencer_unit import rlos_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_led_bits,
   input  logic [15:0] req_start_delay,
   input  logic [15:0] req_run_time,
   input  logic [7:0]  req_weak_level,
   input  logic [7:0]  req_strong_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_weak_motor_on,
   output logic [7:0]  rsp_strong_force,
   output logic [7:0]  rsp_motor_hold,
   output logic [4:0]  rsp_led_byte,
   output logic        rsp_interrupt_channel,
   output logic        rsp_last_copy,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_clone_mode
);

   logic       clone_mode_ff;
   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_head_valid;
   report_type q_push_data;
   report_type q_head_data;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clone_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         clone_mode_ff <= csr_clone_mode;
      end
   end

   // item intake and sequencing
   rlos_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_led_bits     (req_led_bits),
      .req_start_delay  (req_start_delay),
      .req_run_time     (req_run_time),
      .req_weak_level   (req_weak_level),
      .req_strong_level (req_strong_level),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_push_data)
   );

   // report queue
   rlos_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   // report output and copying
   rlos_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .clone_mode            (clone_mode_ff),
      .head_valid            (q_head_valid),
      .head_data             (q_head_data),
      .pop                   (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_weak_motor_on     (rsp_weak_motor_on),
      .rsp_strong_force      (rsp_strong_force),
      .rsp_motor_hold        (rsp_motor_hold),
      .rsp_led_byte          (rsp_led_byte),
      .rsp_interrupt_channel (rsp_interrupt_channel),
      .rsp_last_copy         (rsp_last_copy)
   );

endmodule
